// ----- hdl/mi4_pkg.sv -----
// Package for the 4x4 fixed-point matrix inverse.
// Holds the sequencer state type, the minor and adjugate index tables and shared constants.
// Used by every module of the block; depends on nothing.
package mi4_pkg;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_MINOR,
		ST_ADJ,
		ST_DET,
		ST_DIV
	} state_t;

	localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam int Q_BITS = 40;
	localparam int NUM_MINORS = 18;

	// Each minor packs row r, row s, column x, column y as four 2-bit fields.
	localparam logic [7:0] MINOR_TAB [NUM_MINORS] = '{
		8'hBB, 8'hB7, 8'hB6, 8'hB3, 8'hB2, 8'hB1,
		8'h7B, 8'h77, 8'h76, 8'h6B, 8'h67, 8'h66,
		8'h73, 8'h72, 8'h63, 8'h62, 8'h71, 8'h61
	};

	// Matrix entries of the three cofactor terms, one nibble each.
	localparam logic [11:0] ADJ_ENT [16] = '{
		12'h567, 12'h123, 12'h123, 12'h123,
		12'h467, 12'h023, 12'h023, 12'h023,
		12'h457, 12'h013, 12'h013, 12'h013,
		12'h456, 12'h012, 12'h012, 12'h012
	};

	// Minor numbers of the three cofactor terms, five bits each.
	localparam logic [14:0] ADJ_MIN [16] = '{
		{5'd0, 5'd1, 5'd2}, {5'd0, 5'd1, 5'd2}, {5'd6, 5'd7, 5'd8}, {5'd9, 5'd10, 5'd11},
		{5'd0, 5'd3, 5'd4}, {5'd0, 5'd3, 5'd4}, {5'd6, 5'd12, 5'd13}, {5'd9, 5'd14, 5'd15},
		{5'd1, 5'd3, 5'd5}, {5'd1, 5'd3, 5'd5}, {5'd7, 5'd12, 5'd16}, {5'd10, 5'd14, 5'd17},
		{5'd2, 5'd4, 5'd5}, {5'd2, 5'd4, 5'd5}, {5'd8, 5'd13, 5'd16}, {5'd11, 5'd15, 5'd17}
	};

	// Adjugate entries that are negated at the end.
	localparam logic [15:0] ADJ_NEG = 16'h5A5A;

endpackage

// ----- hdl/mi4_mul.sv -----
// Shared 33x33 signed multiplier with a registered product.
// Serves the exact minor products and the partial products of the wide terms.
// Depends on mi4_pkg.
module mi4_mul
	import mi4_pkg::*;
(
	input  logic               clk,
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic signed [65:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

// ----- hdl/mi4_div.sv -----
// Restoring divider, one quotient bit per cycle, for one inverse entry.
// Forms |adj| * 2^FRAC_BITS / |det|, rounds half away from zero and saturates to 32 bits.
// Depends on mi4_pkg.
module mi4_div
	import mi4_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num_mag,
	input  logic [63:0] den_mag,
	input  logic        neg,
	output logic        done,
	output logic [31:0] result
);

	localparam int NW = 64 + FRAC_BITS;
	localparam int CW = $clog2(NW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] num_q;
	logic [63:0]   rem_q;
	logic [63:0]   den_q;
	logic [Q_BITS-1:0] quo_q;
	logic          big_q;
	logic          neg_q;

	logic [64:0] rem_sh;
	logic [64:0] rem_sub;
	logic        fits;
	logic        low_bit;
	logic        half;
	logic [Q_BITS:0] q_rnd;
	logic [Q_BITS:0] lim;
	logic [Q_BITS:0] q_sat;
	logic [Q_BITS:0] q_neg;

	always_comb begin
		rem_sh  = {rem_q, num_q[NW-1]};
		fits    = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
		low_bit = cnt_q < CW'(Q_BITS);
		half    = {rem_q, 1'b0} >= {1'b0, den_q};
		q_rnd   = {1'b0, quo_q} + (Q_BITS+1)'(!big_q && half);
		lim     = neg_q ? (Q_BITS+1)'(33'h0_8000_0000) : (Q_BITS+1)'(33'h0_7FFF_FFFF);
		q_sat   = (big_q || (q_rnd > lim)) ? lim : q_rnd;
		q_neg   = '0 - q_sat;
		result  = neg_q ? q_neg[31:0] : q_sat[31:0];
	end

	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q && (cnt_q == '0)) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {num_mag, {FRAC_BITS{1'b0}}};
			rem_q <= '0;
			den_q <= den_mag;
			quo_q <= '0;
			big_q <= 1'b0;
			neg_q <= neg;
			cnt_q <= CW'(NW - 1);
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			rem_q <= fits ? rem_sub[63:0] : rem_sh[63:0];
			quo_q <= {quo_q[Q_BITS-2:0], fits && low_bit};
			if (fits && !low_bit) begin
				big_q <= 1'b1;
			end
			cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

// ----- hdl/matrix_inverse_4x4.sv -----
// Top level of the 4x4 fixed-point matrix inverse by the cofactor method.
// Holds the matrix and scratch memories and the sequencer; uses mi4_mul, mi4_div and mi4_pkg.
//
// Channel  Signals                                      Dir  Meaning
// in       in_valid, in_ready, element                  in   one matrix entry, row-major
// out      out_valid, out_ready, inverse_element,       out  one inverse entry, row-major
//          singular, last
//
// Entries load one per cycle while in_ready is high. After the sixteenth, the sequencer forms
// the eighteen minors, then the adjugate and then the determinant, all through the one
// multiplier and one port of each memory. Each output then passes through the bit-serial
// divider. A stalled output holds the sequencer; new entries are taken once the last output
// sits in the output register. Reset needs no memory clearing.
module matrix_inverse_4x4
	import mi4_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [31:0] element,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] inverse_element,
	output logic        singular,
	output logic        last
);

	localparam logic signed [64:0] SAT_HI = {1'b0, SAT_MAX};
	localparam logic signed [64:0] SAT_LO = -SAT_HI;

	logic [31:0] mat_mem [16];
	logic [63:0] scr_mem [64];

	state_t      state_q, state_d;
	logic [2:0]  sub_q, sub_d;
	logic [4:0]  idx_q, idx_d;
	logic [1:0]  term_q, term_d;
	logic [3:0]  load_q;
	logic        out_valid_q;

	logic [3:0]  mat_raddr;
	logic [5:0]  scr_raddr;
	logic        scr_we;
	logic [5:0]  scr_waddr;
	logic [63:0] scr_wdata;
	logic        div_start;
	logic        out_load;
	logic        in_acc;

	logic [31:0] mat_rd_q;
	logic [63:0] scr_rd_q;
	logic [31:0] opa_q;
	logic [31:0] opb_q;
	logic [31:0] whi_q;
	logic        neg_q;
	logic [95:0] prod_q;
	logic [63:0] tmag_q;
	logic signed [63:0] acc_q;
	logic signed [31:0] inv_q;
	logic        sing_q;
	logic        last_q;

	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] mp_q;

	logic [7:0]  mt;
	logic [3:0]  adj_ent;
	logic [4:0]  adj_min;
	logic [31:0] mat_mag;
	logic [63:0] scr_mag;
	logic [63:0] det_mag;
	logic [96:0] rnd_a;
	logic [96:0] rnd_d;
	logic [96:0] rnd_sh;
	logic [63:0] rnd_mag;
	logic        term_neg;
	logic signed [63:0] term_val;
	logic signed [64:0] acc_sum;
	logic signed [63:0] acc_sat;
	logic        det_zero;
	logic        div_done;
	logic [31:0] div_res;

	mi4_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mp_q)
	);

	mi4_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num_mag (scr_mag),
		.den_mag (det_mag),
		.neg     (scr_rd_q[63] ^ acc_q[63]),
		.done    (div_done),
		.result  (div_res)
	);

	assign in_ready        = (state_q == ST_LOAD);
	assign in_acc          = in_valid && in_ready;
	assign out_valid       = out_valid_q;
	assign inverse_element = inv_q;
	assign singular        = sing_q;
	assign last            = last_q;

	always_comb begin
		mt       = MINOR_TAB[idx_q];
		mat_mag  = mat_rd_q[31] ? (32'd0 - mat_rd_q) : mat_rd_q;
		scr_mag  = scr_rd_q[63] ? (64'd0 - scr_rd_q) : scr_rd_q;
		det_mag  = acc_q[63] ? (64'd0 - acc_q) : acc_q;
		det_zero = (acc_q == '0);
		unique case (term_q)
			2'd0: begin
				adj_ent = ADJ_ENT[idx_q[3:0]][11:8];
				adj_min = ADJ_MIN[idx_q[3:0]][14:10];
			end
			2'd1: begin
				adj_ent = ADJ_ENT[idx_q[3:0]][7:4];
				adj_min = ADJ_MIN[idx_q[3:0]][9:5];
			end
			default: begin
				adj_ent = ADJ_ENT[idx_q[3:0]][3:0];
				adj_min = ADJ_MIN[idx_q[3:0]][4:0];
			end
		endcase
		if (state_q == ST_MINOR) begin
			mul_a = {opa_q[31], opa_q};
			mul_b = {opb_q[31], opb_q};
		end else begin
			mul_a = {1'b0, opa_q};
			mul_b = {1'b0, opb_q};
		end
		rnd_a    = {1'b0, prod_q} + (97'd1 << (2 * FRAC_BITS - 1));
		rnd_d    = {1'b0, prod_q} + (97'd1 << (FRAC_BITS - 1));
		rnd_sh   = (state_q == ST_ADJ) ? (rnd_a >> (2 * FRAC_BITS)) : (rnd_d >> FRAC_BITS);
		rnd_mag  = (|rnd_sh[96:63]) ? SAT_MAX : {1'b0, rnd_sh[62:0]};
		term_neg = neg_q ^ ((state_q == ST_ADJ) && (term_q == 2'd1));
		term_val = term_neg ? -$signed(tmag_q) : $signed(tmag_q);
		acc_sum  = {acc_q[63], acc_q} + {term_val[63], term_val};
		if (acc_sum > SAT_HI) begin
			acc_sat = SAT_HI[63:0];
		end else if (acc_sum < SAT_LO) begin
			acc_sat = SAT_LO[63:0];
		end else begin
			acc_sat = acc_sum[63:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			sub_q       <= '0;
			idx_q       <= '0;
			term_q      <= '0;
			load_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sub_q   <= sub_d;
			idx_q   <= idx_d;
			term_q  <= term_d;
			if (in_acc) begin
				load_q <= load_q + 4'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		sub_d     = sub_q;
		idx_d     = idx_q;
		term_d    = term_q;
		mat_raddr = '0;
		scr_raddr = '0;
		scr_we    = 1'b0;
		scr_waddr = {1'b0, idx_q};
		scr_wdata = acc_q - mp_q[63:0];
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc && (load_q == 4'd15)) begin
					state_d = ST_MINOR;
					sub_d   = '0;
					idx_d   = '0;
					term_d  = '0;
				end
			end
			ST_MINOR: begin
				sub_d = sub_q + 3'd1;
				unique case (sub_q)
					3'd0: mat_raddr = {mt[7:6], mt[3:2]};
					3'd1: mat_raddr = {mt[5:4], mt[1:0]};
					3'd2: mat_raddr = {mt[7:6], mt[1:0]};
					3'd3: mat_raddr = {mt[5:4], mt[3:2]};
					3'd6: begin
						scr_we = 1'b1;
						sub_d  = '0;
						if (idx_q == 5'(NUM_MINORS - 1)) begin
							state_d = ST_ADJ;
							idx_d   = '0;
						end else begin
							idx_d = idx_q + 5'd1;
						end
					end
					default: ;
				endcase
			end
			ST_ADJ, ST_DET: begin
				sub_d = sub_q + 3'd1;
				if (state_q == ST_ADJ) begin
					mat_raddr = adj_ent;
					scr_raddr = {1'b0, adj_min};
				end else begin
					mat_raddr = {2'b00, term_q};
					scr_raddr = {2'b10, term_q, 2'b00};
				end
				if (sub_q == 3'd6) begin
					if (state_q == ST_DET) begin
						sub_d = '0;
						if (term_q == 2'd3) begin
							state_d = ST_DIV;
							idx_d   = '0;
							term_d  = '0;
						end else begin
							term_d = term_q + 2'd1;
						end
					end else if (term_q != 2'd2) begin
						sub_d  = '0;
						term_d = term_q + 2'd1;
					end
				end else if (sub_q == 3'd7) begin
					scr_we    = 1'b1;
					scr_waddr = {2'b10, idx_q[3:0]};
					scr_wdata = ADJ_NEG[idx_q[3:0]] ? -acc_q : acc_q;
					sub_d     = '0;
					term_d    = '0;
					if (idx_q == 5'd15) begin
						state_d = ST_DET;
						idx_d   = '0;
					end else begin
						idx_d = idx_q + 5'd1;
					end
				end
			end
			ST_DIV: begin
				scr_raddr = {2'b10, idx_q[3:0]};
				unique case (sub_q)
					3'd0: sub_d = 3'd1;
					3'd1: begin
						div_start = 1'b1;
						sub_d     = 3'd2;
					end
					default: begin
						if ((det_zero || div_done) && (!out_valid_q || out_ready)) begin
							out_load = 1'b1;
							sub_d    = '0;
							if (idx_q == 5'd15) begin
								state_d = ST_LOAD;
								idx_d   = '0;
							end else begin
								idx_d = idx_q + 5'd1;
							end
						end
					end
				endcase
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mat_mem[load_q] <= element;
		end
		mat_rd_q <= mat_mem[mat_raddr];
		if (scr_we) begin
			scr_mem[scr_waddr] <= scr_wdata;
		end
		scr_rd_q <= scr_mem[scr_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MINOR) begin
			unique case (sub_q)
				3'd1, 3'd3: opa_q <= mat_rd_q;
				3'd2: opb_q <= mat_rd_q;
				3'd4: begin
					opb_q <= mat_rd_q;
					acc_q <= mp_q[63:0];
				end
				3'd6: acc_q <= '0;
				default: ;
			endcase
		end else if ((state_q == ST_ADJ) || (state_q == ST_DET)) begin
			unique case (sub_q)
				3'd1: begin
					opa_q <= mat_mag;
					opb_q <= scr_mag[31:0];
					whi_q <= scr_mag[63:32];
					neg_q <= mat_rd_q[31] ^ scr_rd_q[63];
				end
				3'd2: opb_q <= whi_q;
				3'd3: prod_q <= {32'd0, mp_q[63:0]};
				3'd4: prod_q <= prod_q + {mp_q[63:0], 32'd0};
				3'd5: tmag_q <= rnd_mag;
				3'd6: acc_q <= acc_sat;
				3'd7: acc_q <= '0;
				default: ;
			endcase
		end
		if (out_load) begin
			inv_q  <= det_zero ? 32'sd0 : $signed(div_res);
			sing_q <= det_zero;
			last_q <= (idx_q == 5'd15);
		end
	end

endmodule
